@@ src/svs_pkg.sv @@
`timescale 1ns / 1ps

package svs_pkg;

    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SORT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Result strobe and status handed from the sequencer to the output register.
    typedef struct packed {
        logic            load;
        logic [ST_W-1:0] status;
    } t_rsp_ctl;

endpackage

@@ src/svs_if.sv @@
`timescale 1ns / 1ps

interface svs_cmd_if;
    import svs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface svs_rsp_if #(
    parameter int CNT_W = 9
);
    import svs_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] pop_value;
    logic [CNT_W-1:0]  entry_total;
    logic [ST_W-1:0]   status;

    modport source (output valid, output pop_value, output entry_total, output status,
                    input ready);
    modport sink   (input valid, input pop_value, input entry_total, input status,
                    output ready);
endinterface

@@ src/svs_ram.sv @@
`timescale 1ns / 1ps

module svs_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/svs_ctrl.sv @@
`timescale 1ns / 1ps

module svs_ctrl #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 8,
    parameter int CNT_W       = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic [svs_pkg::OP_W-1:0]  i_cmd_op,
    input  logic [svs_pkg::DATA_W-1:0] i_cmd_value,
    output logic                      o_cmd_ready,
    input  logic                      i_rsp_free,
    output svs_pkg::t_rsp_ctl         o_rsp_ctl,
    output logic [svs_pkg::DATA_W-1:0] o_pop_value,
    output logic [CNT_W-1:0]          o_count,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [VALUE_WIDTH-1:0]    o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  logic [VALUE_WIDTH-1:0]    i_rdata
);
    import svs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_KEY,
        S_CMP,
        S_PLACE
    } t_state;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [AW-1:0]          r_i, n_i;
    logic [AW-1:0]          r_j, n_j;
    logic [VALUE_WIDTH-1:0] r_key, n_key;

    logic [VALUE_WIDTH-1:0] push_w;
    logic [DATA_W-1:0]      rd_w;
    logic                   accept;
    logic                   gt;
    logic                   last_key;

    generate
        if (VALUE_WIDTH > DATA_W) begin : g_wide
            assign push_w = {{(VALUE_WIDTH-DATA_W){1'b0}}, i_cmd_value};
            assign rd_w   = i_rdata[DATA_W-1:0];
        end else if (VALUE_WIDTH < DATA_W) begin : g_narrow
            assign push_w = i_cmd_value[VALUE_WIDTH-1:0];
            assign rd_w   = {{(DATA_W-VALUE_WIDTH){1'b0}}, i_rdata};
        end else begin : g_same
            assign push_w = i_cmd_value;
            assign rd_w   = i_rdata;
        end
    endgenerate

    assign o_cmd_ready = (r_state == S_IDLE) && i_rsp_free;
    assign accept      = i_cmd_valid && o_cmd_ready;
    // The single comparator, used by the compare step of the sort.
    assign gt          = i_rdata > r_key;
    assign last_key    = ({{(CNT_W-AW){1'b0}}, r_i} + CNT_W'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_key       = r_key;
        o_rsp_ctl   = '{load: 1'b0, status: ST_OK};
        o_pop_value = '0;
        o_we        = 1'b0;
        o_waddr     = r_j;
        o_wdata     = r_key;
        o_raddr     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd_op)
                        OP_PUSH: begin
                            o_rsp_ctl.load = 1'b1;
                            if (r_count == FULL_COUNT) begin
                                o_rsp_ctl.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_count[AW-1:0];
                                o_wdata = push_w;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                o_rsp_ctl = '{load: 1'b1, status: ST_EMPTY};
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                o_raddr = n_count[AW-1:0];
                                n_state = S_POP;
                            end
                        end
                        OP_SORT: begin
                            if (r_count < CNT_W'(2)) begin
                                o_rsp_ctl.load = 1'b1;
                            end else begin
                                n_i     = AW'(1);
                                o_raddr = AW'(1);
                                n_state = S_KEY;
                            end
                        end
                        default: begin
                            o_rsp_ctl.load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                o_rsp_ctl.load = 1'b1;
                o_pop_value    = rd_w;
                n_state        = S_IDLE;
            end
            S_KEY: begin
                n_key   = i_rdata;
                n_j     = r_i;
                o_raddr = r_i - AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                o_we = 1'b1;
                if (gt) begin
                    // Shift the larger neighbour up one place.
                    o_wdata = i_rdata;
                    n_j     = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        o_raddr = r_j - AW'(2);
                    end
                end else begin
                    if (last_key) begin
                        o_rsp_ctl.load = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        o_raddr = n_i;
                        n_state = S_KEY;
                    end
                end
            end
            S_PLACE: begin
                o_we = 1'b1;
                if (last_key) begin
                    o_rsp_ctl.load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_i     = r_i + AW'(1);
                    o_raddr = n_i;
                    n_state = S_KEY;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
    end

endmodule

@@ src/sortable_value_stack.sv @@
`timescale 1ns / 1ps
// Timing: a push, a refused pop, a sort of fewer than two entries and a no-operation code
// load their result into the output register in the cycle after acceptance; a successful pop
// first waits for the registered memory read. A sort's duration grows with the entry count n
// and with d, the number of out-of-order pairs, set by the single compare unit and the memory walk.
// Throughput: one item at a time; a new item is taken once the last result is handed on.
// Reset (synchronous, active low) empties the stack; stored values are not cleared.

module sortable_value_stack #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    svs_cmd_if.sink i_cmd,
    svs_rsp_if.source o_rsp
);
    import svs_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_rsp_ctl               rsp_ctl;
    logic [DATA_W-1:0]      pop_value;
    logic [CNT_W-1:0]       count;
    logic                   rsp_free;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] rdata;

    // Output register: holds one result until the consumer takes it.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_pop;
    logic [CNT_W-1:0]  r_out_total;
    logic [ST_W-1:0]   r_out_status;

    // The sequencer only starts a new item when the output register is empty or is
    // being emptied in this cycle, so a finished result never finds it occupied.
    assign rsp_free = !r_out_valid || o_rsp.ready;

    svs_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_cmd_op    (i_cmd.operation),
        .i_cmd_value (i_cmd.push_value),
        .o_cmd_ready (i_cmd.ready),
        .i_rsp_free  (rsp_free),
        .o_rsp_ctl   (rsp_ctl),
        .o_pop_value (pop_value),
        .o_count     (count),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // The value store: one write and one registered read per cycle.
    svs_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .W     (VALUE_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (rsp_ctl.load) begin
            r_out_pop    <= pop_value;
            r_out_total  <= count;
            r_out_status <= rsp_ctl.status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.pop_value   = r_out_pop;
    assign o_rsp.entry_total = r_out_total;
    assign o_rsp.status      = r_out_status;

endmodule
